/* src/utf8_to_cp1251_converter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the UTF-8 to Windows-1251 converter
// Concurrent checks, clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CP1251_CONVERTER_ASSERT_SVH
`define UTF8_TO_CP1251_CONVERTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U2CP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U2CP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/u2cp_pkg.sv */
// ----------------------------------------------------------------------------
// u2cp_pkg
// Types, constants and the code point to Windows-1251 mapping.
// ----------------------------------------------------------------------------
package u2cp_pkg;

    typedef logic [31:0] t_code_point;
    typedef logic [3:0]  t_ones_cnt;
    typedef logic [2:0]  t_remaining;

    localparam int CP_TABLE_SIZE = 62;

    localparam t_code_point CYR_FIRST  = 32'h0000_0410;
    localparam t_code_point CYR_LAST   = 32'h0000_044F;
    localparam t_code_point CYR_OFFSET = 32'h0000_0350;
    localparam t_code_point ASCII_MAX  = 32'h0000_007F;
    localparam logic [7:0]  SPACE_CHAR = 8'h20;

    localparam logic [15:0] CP_CODE [CP_TABLE_SIZE] = '{
        16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
        16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F, 16'h00A0,
        16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7, 16'h0401,
        16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AE, 16'h0407, 16'h00B0, 16'h00B1,
        16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7, 16'h0451, 16'h2116,
        16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
    };

    localparam logic [7:0] CP_BYTE [CP_TABLE_SIZE] = '{
        8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
        8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F,
        8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97,
        8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'hA0,
        8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hA8,
        8'hA9, 8'hAA, 8'hAB, 8'hAC, 8'hAE, 8'hAF, 8'hB0, 8'hB1,
        8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hB9,
        8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF
    };

    // Number of leading ones of a byte, 0 to 8.
    function automatic t_ones_cnt lead_ones(input logic [7:0] b);
        t_ones_cnt n;
        case (b) inside
            8'b0???????: n = 4'd0;
            8'b10??????: n = 4'd1;
            8'b110?????: n = 4'd2;
            8'b1110????: n = 4'd3;
            8'b11110???: n = 4'd4;
            8'b111110??: n = 4'd5;
            8'b1111110?: n = 4'd6;
            8'b11111110: n = 4'd7;
            default:     n = 4'd8;
        endcase
        return n;
    endfunction

    // Map a completed code point to its Windows-1251 byte; zero and unmapped code points become space.
    function automatic logic [7:0] map_cp(input t_code_point v);
        logic [7:0] r;
        r = '0;
        if (v >= CYR_FIRST && v <= CYR_LAST) begin
            r = 8'(v - CYR_OFFSET);
        end else if (v > ASCII_MAX) begin
            // table codes are distinct, so at most one entry hits
            for (int k = 0; k < CP_TABLE_SIZE; k++) begin
                if (v == 32'(CP_CODE[k])) begin
                    r = r | CP_BYTE[k];
                end
            end
        end else begin
            r = v[7:0];
        end
        if (r == '0) begin
            r = SPACE_CHAR;
        end
        return r;
    endfunction

endpackage

/* src/utf8_to_cp1251_converter.sv */
// Throughput: one byte per cycle through the three-register pipeline (input, code,
// output) when i_m_tready does not stall it; the output register drives o_m_*.
// Backpressure from i_m_tready stalls each stage only when the stage after it is full.
// Reset (i_rst_n low, synchronous) empties all stages and clears the decode state.
// ----------------------------------------------------------------------------
// utf8_to_cp1251_converter
// Decodes a UTF-8 byte stream and emits one Windows-1251 byte per code point.
// ----------------------------------------------------------------------------
`include "utf8_to_cp1251_converter_assert.svh"

module utf8_to_cp1251_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // end_of_text
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast    // out_last
);
    import u2cp_pkg::*;

    // input stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eot;

    // decode state
    t_remaining  r_rem,  n_rem;
    t_code_point r_acc,  n_acc;

    // completed code point stage
    logic        r_cp_valid;
    t_code_point r_cp;
    logic        r_cp_last;

    // output stage
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        out_adv;
    logic        cp_adv;
    logic        in_fire;
    logic        done;
    t_ones_cnt   ones;
    t_remaining  rem_dec;
    t_code_point lead_val;
    t_code_point cont_val;
    t_code_point acc_sum;

    assign out_adv    = !r_out_valid || i_m_tready;
    assign cp_adv     = !r_cp_valid || out_adv;
    assign in_fire    = r_in_valid && cp_adv;
    assign o_s_tready = !r_in_valid || cp_adv;

    assign ones    = lead_ones(r_in_byte);
    assign rem_dec = r_rem - 3'd1;

    // lead byte payload placed at 6*(n-1); shifts of 32 or more drop out
    always_comb begin
        case (ones)
            4'd2:    lead_val = t_code_point'(r_in_byte[5:0]) << 6;
            4'd3:    lead_val = t_code_point'(r_in_byte[4:0]) << 12;
            4'd4:    lead_val = t_code_point'(r_in_byte[3:0]) << 18;
            4'd5:    lead_val = t_code_point'(r_in_byte[2:0]) << 24;
            4'd6:    lead_val = t_code_point'(r_in_byte[1:0]) << 30;
            default: lead_val = '0;
        endcase
    end

    // continuation byte placed at 6 times the bytes still to come
    always_comb begin
        case (rem_dec)
            3'd0:    cont_val = t_code_point'(r_in_byte[6:0]);
            3'd1:    cont_val = t_code_point'(r_in_byte[6:0]) << 6;
            3'd2:    cont_val = t_code_point'(r_in_byte[6:0]) << 12;
            3'd3:    cont_val = t_code_point'(r_in_byte[6:0]) << 18;
            3'd4:    cont_val = t_code_point'(r_in_byte[6:0]) << 24;
            3'd5:    cont_val = t_code_point'(r_in_byte[6:0]) << 30;
            default: cont_val = '0;
        endcase
    end

    assign acc_sum = r_acc + cont_val;

    always_comb begin
        if (r_rem == '0) begin
            if (ones < 4'd2) begin
                n_acc = t_code_point'(r_in_byte[6:0]);
                n_rem = '0;
                done  = 1'b1;
            end else begin
                n_acc = lead_val;
                n_rem = t_remaining'(ones - 4'd1);
                done  = 1'b0;
            end
        end else begin
            n_acc = acc_sum;
            n_rem = rem_dec;
            done  = (rem_dec == '0);
        end
        // end of text closes any open sequence, missing bytes count as zero
        if (r_in_eot) begin
            done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_eot  <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_acc <= '0;
        end else if (in_fire) begin
            if (done) begin
                r_rem <= '0;
                r_acc <= '0;
            end else begin
                r_rem <= n_rem;
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_valid <= 1'b0;
        end else if (cp_adv) begin
            r_cp_valid <= in_fire && done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && done) begin
            r_cp      <= n_acc;
            r_cp_last <= r_in_eot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_cp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_cp_valid) begin
            r_out_byte <= map_cp(r_cp);
            r_out_last <= r_cp_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

    `U2CP_ASSERT_NEXT(a_cp_hold, !cp_adv, r_cp_valid && $stable(r_cp), "code point not held")
    `U2CP_ASSERT_NEXT(a_eot_clears, in_fire && r_in_eot, r_rem == '0 && r_acc == '0, "state kept")
    `U2CP_ASSERT_NEXT(a_eot_emits, in_fire && r_in_eot, r_cp_valid && r_cp_last, "no final char")
    `U2CP_ASSERT_SAME(a_no_zero_out, o_m_tvalid, o_m_tdata != 8'h00, "zero byte emitted")

endmodule
